@@ hw/rtl/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg: shared types for the DDA line rasterizer
// Request and pixel payloads, operation codes, sequencer states and the
// control/status structs between the sequencer and the slope divider.
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int COORD_BITS = 12;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} dda_op_t;

	typedef struct packed {
		dda_op_t operation;
		coord_t  start_x;
		coord_t  start_y;
		coord_t  end_x;
		coord_t  end_y;
	} dda_req_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   pixel_valid;
		logic   pixel_last;
	} dda_pix_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} dda_state_t;

	typedef struct packed {
		logic start;
	} dda_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dda_div_stat_t;

endpackage

@@ hw/rtl/dda_div.sv @@
// ----------------------------------------------------------------------------
// dda_div: iterative slope divider
// Restoring shift-subtract divider, one quotient bit per cycle. Computes
// floor(dividend * 2^FRAC_BITS / divisor) for dividend <= divisor.
// ----------------------------------------------------------------------------
module dda_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dda_pkg::dda_div_ctl_t             ctl,
	output dda_pkg::dda_div_stat_t            stat,
	input  logic [dda_pkg::COORD_BITS-1:0]    dividend,
	input  logic [dda_pkg::COORD_BITS-1:0]    divisor,
	output logic [FRAC_BITS:0]                quotient
);
	import dda_pkg::*;

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] dsr_q;
	logic [FRAC_BITS:0]    quo_q;

	logic [COORD_BITS:0]   rem2;
	logic                  ge;
	logic [COORD_BITS:0]   diff;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, dsr_q};
	assign diff = rem2 - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands are at most equal, so the integer quotient bit is a compare
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dsr_q <= divisor;
			if (dividend == divisor) begin
				rem_q <= '0;
				quo_q <= (FRAC_BITS+1)'(1);
			end else begin
				rem_q <= dividend;
				quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[COORD_BITS-1:0] : rem2[COORD_BITS-1:0];
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with zero count");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
`endif

endmodule

@@ hw/rtl/dda_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// dda_line_rasterizer: DDA line pixel generator
// Start requests load endpoints and emit the first pixel; step requests
// advance one pixel, marking the endpoint as last; with no line, an empty pixel.
// ----------------------------------------------------------------------------
// Every request's pixel is in the output register the cycle after accept.
// Step requests: one per cycle while the output keeps up and the divider is idle.
// Start requests: the bit-serial slope divider (one quotient bit per cycle)
//   holds off further requests until the minor step is set; a point-only line skips it.
// Reset (arst_n low, async): no line active, output register empty, divider idle.
module dda_line_rasterizer #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  dda_pkg::dda_req_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output dda_pkg::dda_pix_t rsp
);
	import dda_pkg::*;

	localparam int ACC_W = COORD_BITS + FRAC_BITS;

	// round to nearest, halves up: floor((acc + 0.5) >> FRAC_BITS)
	function automatic coord_t round_acc(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] t;
		t = {a[ACC_W-1], a} + ((ACC_W+1)'(1) <<< (FRAC_BITS - 1));
		return t[FRAC_BITS +: COORD_BITS];
	endfunction

	// ---- sequencer state ----
	dda_state_t state_q, state_d;

	// ---- line state ----
	logic                    active_q;
	logic [COORD_BITS-1:0]   steps_left_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
	logic signed [ACC_W-1:0] step_x_q, step_y_q;
	logic                    x_major_q;   // minor step lands in step_y
	logic                    minor_neg_q;

	// ---- output register ----
	logic     rsp_valid_q;
	dda_pix_t rsp_q;

	// ---- divider link ----
	dda_div_ctl_t          div_ctl;
	dda_div_stat_t         div_stat;
	logic [FRAC_BITS:0]    div_quo;

	logic cmd_fire;
	logic is_start;

	// ---- start request decode ----
	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS:0]        adx_w, ady_w;
	logic [COORD_BITS-1:0]      adx, ady;
	logic                       x_major;
	logic [COORD_BITS-1:0]      major_mag, minor_mag;
	logic                       minor_neg;
	logic signed [ACC_W-1:0]    one_fx;
	logic signed [ACC_W-1:0]    start_acc_x, start_acc_y;

	// ---- step path ----
	logic signed [ACC_W-1:0]    nxt_acc_x, nxt_acc_y;
	logic signed [ACC_W-1:0]    minor_step;
	logic                       step_last;

	assign dx      = {cmd.end_x[COORD_BITS-1], cmd.end_x}
	               - {cmd.start_x[COORD_BITS-1], cmd.start_x};
	assign dy      = {cmd.end_y[COORD_BITS-1], cmd.end_y}
	               - {cmd.start_y[COORD_BITS-1], cmd.start_y};
	assign adx_w   = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
	assign ady_w   = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
	// |delta| never exceeds 2^COORD_BITS - 1
	assign adx     = adx_w[COORD_BITS-1:0];
	assign ady     = ady_w[COORD_BITS-1:0];
	assign x_major = adx >= ady;   // ties go to x

	assign major_mag = x_major ? adx : ady;
	assign minor_mag = x_major ? ady : adx;
	assign minor_neg = x_major ? dy[COORD_BITS] : dx[COORD_BITS];

	assign one_fx      = ACC_W'(1) <<< FRAC_BITS;
	assign start_acc_x = {cmd.start_x, {FRAC_BITS{1'b0}}};
	assign start_acc_y = {cmd.start_y, {FRAC_BITS{1'b0}}};

	assign nxt_acc_x = acc_x_q + step_x_q;
	assign nxt_acc_y = acc_y_q + step_y_q;
	assign step_last = steps_left_q == COORD_BITS'(1);

	// quotient <= 2^FRAC_BITS, so it fits with room for the sign
	assign minor_step = minor_neg_q ? -ACC_W'(div_quo) : ACC_W'(div_quo);

	assign is_start      = cmd.operation == OP_START;
	assign cmd_fire      = cmd_valid && cmd_ready;
	assign div_ctl.start = cmd_fire && is_start && (major_mag != '0);

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (div_ctl.start) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer outputs ----
	always_comb begin
		cmd_ready = 1'b0;
		case (state_q)
			ST_IDLE: cmd_ready = !rsp_valid_q || rsp_ready;
			ST_DIV:  cmd_ready = 1'b0;
			default: cmd_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= 1'b0;
			steps_left_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_fire) begin
				rsp_valid_q <= 1'b1;
				if (is_start) begin
					active_q     <= major_mag != '0;
					steps_left_q <= major_mag;
				end else if (active_q) begin
					active_q     <= !step_last;
					steps_left_q <= steps_left_q - 1'b1;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath: accumulators, steps and the output payload
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			if (is_start) begin
				acc_x_q     <= start_acc_x;
				acc_y_q     <= start_acc_y;
				x_major_q   <= x_major;
				minor_neg_q <= minor_neg;
				// major axis moves one whole pixel; minor step waits for the divider
				if (x_major) begin
					step_x_q <= dx[COORD_BITS] ? -one_fx : one_fx;
					step_y_q <= '0;
				end else begin
					step_y_q <= dy[COORD_BITS] ? -one_fx : one_fx;
					step_x_q <= '0;
				end
				rsp_q.pixel_x     <= cmd.start_x;
				rsp_q.pixel_y     <= cmd.start_y;
				rsp_q.pixel_valid <= 1'b1;
				rsp_q.pixel_last  <= major_mag == '0;
			end else if (active_q) begin
				acc_x_q           <= nxt_acc_x;
				acc_y_q           <= nxt_acc_y;
				rsp_q.pixel_x     <= round_acc(nxt_acc_x);
				rsp_q.pixel_y     <= round_acc(nxt_acc_y);
				rsp_q.pixel_valid <= 1'b1;
				rsp_q.pixel_last  <= step_last;
			end else begin
				// step with no line
				rsp_q <= '0;
			end
		end else if (state_q == ST_DIV && div_stat.done) begin
			if (x_major_q) step_y_q <= minor_step;
			else           step_x_q <= minor_step;
		end
	end

	dda_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.stat     (div_stat),
		.dividend (minor_mag),
		.divisor  (major_mag),
		.quotient (div_quo)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !cmd_ready)
		else $error("request taken while slope divide in flight");

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> steps_left_q != '0)
		else $error("line active with no steps left");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.pixel_last |-> !active_q)
		else $error("last pixel issued while line still active");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");
`endif

endmodule
